/* hw/rtl/rwss_pkg.sv */
// Package for the random-walk satisfiability solver.
// Holds shared widths, command codes and the controller/datapath interface structs.
// Depends on nothing.
package rwss_pkg;

  localparam int MaxVars    = 64;
  localparam int MaxClauses = 1024;
  localparam int MaxLits    = 4;

  localparam int CiW  = 10;               // clause index width
  localparam int LitW = 8;                // literal entry: negation bit, 7-bit variable
  localparam int LaW  = CiW + 2;          // literal store address width
  localparam int LenW = 3;
  localparam int CntW = 11;               // clause count width

  typedef enum logic [1:0] {
    CMD_LOAD_LIT = 2'd0,
    CMD_SET_LEN  = 2'd1,
    CMD_START    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_NUM_VARS     = 3'd0,
    CFG_NUM_CLAUSES  = 3'd1,
    CFG_MAX_STEPS    = 3'd2,
    CFG_MAX_ATTEMPTS = 3'd3,
    CFG_RNG_SEED     = 3'd4
  } cfg_idx_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clr_pass;     // clear the length store, one entry per cycle
    logic init_bit;     // draw one random bit into the assignment
    logic scan_start;   // begin a sweep over the clauses
    logic scan_step;    // advance the clause sweep (one literal per cycle)
    logic pick_clause;  // draw and start reduction mod violated count
    logic pick_lit;     // draw and start reduction mod clause length
    logic mod_step;     // one step of the shared remainder unit
    logic rd_viol;      // latch the picked clause length
    logic rd_len;       // latch the picked clause from the violated list
    logic rd_lit;       // read picked literal
    logic flip;         // flip the picked variable
    logic clr_assign;   // clear assignment before an attempt
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic init_done;
    logic scan_done;
    logic viol_zero;
    logic mod_done;
    logic len_zero;
  } dp_sts_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

/* hw/rtl/random_walk_sat_solver.sv */
// Top level of the random-walk satisfiability solver.
// Depends on rwss_pkg, rwss_ctrl, rwss_dp and rwss_ram.
//
// Load requests (literal and clause length) are taken one per cycle while the
// block is idle and no result is waiting. A start request runs the search and
// yields one result request. Each attempt has a setup state and then draws one
// random bit per variable. Each step starts a sweep, reads the length of each
// clause and examines its literals one at a time until one holds, and finishes
// the sweep; when a clause is violated the pick follows, with two 33-step
// remainder reductions in a shared restoring unit, the second skipped when the
// picked clause is empty. After the last check the result passes through the
// attempt and done states into the output register. After reset a clearing
// pass zeroes the length store; no request is accepted during it.
// Configuration registers may only be written while no search is running.
module random_walk_sat_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_clause_index,
  input  logic [1:0]  in_literal_slot,
  input  logic [6:0]  in_literal_var,
  input  logic        in_literal_negative,
  input  logic [2:0]  in_clause_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_assignment,
  output logic [7:0]  out_attempts_used,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [6:0]  nv_r;
  logic [10:0] nc_r;
  logic [15:0] ms_r;
  logic [7:0]  ma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 7'd1;
      nc_r <= 11'd1;
      ms_r <= 16'd40960;
      ma_r <= 8'd100;
    end else if (cfg_we) begin
      case (rwss_pkg::cfg_idx_t'(cfg_index))
        rwss_pkg::CFG_NUM_VARS:     nv_r <= cfg_data[6:0];
        rwss_pkg::CFG_NUM_CLAUSES:  nc_r <= cfg_data[10:0];
        rwss_pkg::CFG_MAX_STEPS:    ms_r <= cfg_data[15:0];
        rwss_pkg::CFG_MAX_ATTEMPTS: ma_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [6:0]  nv_eff;
  logic [10:0] nc_eff;
  assign nv_eff = (nv_r > 7'd64) ? 7'd64 : nv_r;
  assign nc_eff = (nc_r > 11'd1024) ? 11'd1024 : nc_r;

  rwss_pkg::dp_cmd_t dcmd;
  rwss_pkg::dp_sts_t dsts;
  logic        c_ready, c_fin, c_found;
  logic [7:0]  c_att;
  logic [63:0] asg;
  logic        acc;
  logic        ov_r;

  assign in_ready = c_ready & ~ov_r;
  assign acc = in_valid & in_ready;

  rwss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .start(acc && in_cmd == rwss_pkg::CMD_START),
    .max_steps(ms_r), .max_attempts(ma_r),
    .sts(dsts), .cmd(dcmd), .ready(c_ready), .fin(c_fin),
    .found(c_found), .attempts(c_att)
  );

  rwss_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts),
    .lit_we(acc && in_cmd == rwss_pkg::CMD_LOAD_LIT),
    .len_we(acc && in_cmd == rwss_pkg::CMD_SET_LEN),
    .ld_ci(in_clause_index), .ld_slot(in_literal_slot), .ld_var(in_literal_var),
    .ld_neg(in_literal_negative), .ld_len(in_clause_length),
    .nv(nv_eff), .nc(nc_eff),
    .seed_we(cfg_we && cfg_index == rwss_pkg::CFG_RNG_SEED), .seed(cfg_data),
    .assign_o(asg)
  );

  // Output register holds the result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (c_fin) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (c_fin) begin
      out_found         <= c_found;
      out_assignment    <= c_found ? asg : 64'd0;
      out_attempts_used <= c_att;
    end
  end
  assign out_valid = ov_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !c_ready |-> !in_ready) else $error("accept while busy");
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    c_fin |=> out_valid) else $error("result lost");
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_assignment == 64'd0) else $error("assignment leak");
endmodule

/* hw/rtl/rwss_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module rwss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/rwss_dp.sv */
// Datapath of the solver: stores, assignment, generator, clause sweep, remainder unit.
// Depends on rwss_pkg and rwss_ram.
module rwss_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rwss_pkg::dp_cmd_t         cmd,
  output rwss_pkg::dp_sts_t         sts,
  // load path
  input  logic                      lit_we,
  input  logic                      len_we,
  input  logic [rwss_pkg::CiW-1:0]  ld_ci,
  input  logic [1:0]                ld_slot,
  input  logic [6:0]                ld_var,
  input  logic                      ld_neg,
  input  logic [2:0]                ld_len,
  // configuration
  input  logic [6:0]                nv,
  input  logic [rwss_pkg::CntW-1:0] nc,
  input  logic                      seed_we,
  input  logic [31:0]               seed,
  output logic [63:0]               assign_o
);
  // Generator.
  logic [31:0] rnd_r, rnd_nxt;
  logic [31:0] drawn;
  assign drawn = rwss_pkg::xorshift(rnd_r);

  logic draw_en;
  assign draw_en = cmd.init_bit | cmd.pick_clause | cmd.pick_lit;

  always_comb begin
    rnd_nxt = rnd_r;
    if (seed_we) begin
      rnd_nxt = (seed == 32'd0) ? 32'd1 : seed;
    end else if (draw_en) begin
      rnd_nxt = drawn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= 32'd1;
    end else begin
      rnd_r <= rnd_nxt;
    end
  end

  // Clear pass and init counter.
  logic [rwss_pkg::CiW:0] clr_r;
  logic [6:0]             ib_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_pass && !clr_r[rwss_pkg::CiW]) begin
      clr_r <= clr_r + 1'b1;
    end
  end
  assign sts.clr_done = clr_r[rwss_pkg::CiW];

  // Assignment register.
  logic [63:0] asg_r;
  logic [6:0]  flip_var_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asg_r <= '0;
      ib_r  <= '0;
    end else if (cmd.clr_assign) begin
      asg_r <= '0;
      ib_r  <= '0;
    end else if (cmd.init_bit) begin
      asg_r[ib_r[5:0]] <= drawn[0];
      ib_r <= ib_r + 7'd1;
    end else if (cmd.flip) begin
      if (flip_var_r != 7'd0 && flip_var_r <= nv) begin
        asg_r[flip_var_r[5:0] - 6'd1] <= ~asg_r[flip_var_r[5:0] - 6'd1];
      end
    end
  end
  assign sts.init_done = (ib_r >= nv);
  assign assign_o = asg_r;

  // Clause sweep: per clause read length, then each literal one per cycle.
  // Phase: 0 = issue length read, 1 = length valid, then literals.
  typedef enum logic [3:0] {
    SW_IDLE = 4'b0001,
    SW_LEN  = 4'b0010,
    SW_LIT  = 4'b0100,
    SW_EVAL = 4'b1000
  } sw_t;
  sw_t sw_r, sw_nxt;
  logic [rwss_pkg::CntW-1:0] sc_r, sc_nxt;       // clause under test
  logic [2:0]                sj_r, sj_nxt;       // literal issued
  logic [2:0]                slen_r, slen_nxt;
  logic                      shold_r, shold_nxt;
  logic [rwss_pkg::CntW-1:0] vcnt_r, vcnt_nxt;
  logic                      sdone_r, sdone_nxt;

  // Picking.
  logic [rwss_pkg::CiW-1:0]  pc_r;               // picked clause
  logic [2:0]                plen_r;

  // Remainder unit: restoring reduction, one quotient bit per cycle.
  logic [31:0] mrem_r, mrem_nxt;
  logic [43:0] mdiv_r, mdiv_nxt;
  logic [5:0]  mcnt_r, mcnt_nxt;

  always_comb begin
    mrem_nxt = mrem_r;
    mdiv_nxt = mdiv_r;
    mcnt_nxt = mcnt_r;
    if (cmd.pick_clause) begin
      mrem_nxt = drawn;
      mdiv_nxt = {1'b0, vcnt_r, 32'd0};
      mcnt_nxt = 6'd33;
    end else if (cmd.pick_lit) begin
      mrem_nxt = drawn;
      mdiv_nxt = {9'd0, plen_r, 32'd0};
      mcnt_nxt = 6'd33;
    end else if (cmd.mod_step && mcnt_r != 6'd0) begin
      if ({12'd0, mrem_r} >= mdiv_r) begin
        mrem_nxt = 32'(({12'd0, mrem_r} - mdiv_r));
      end
      mdiv_nxt = mdiv_r >> 1;
      mcnt_nxt = mcnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    mrem_r <= mrem_nxt;
    mdiv_r <= mdiv_nxt;
    if (!rst_n) begin
      mcnt_r <= '0;
    end else begin
      mcnt_r <= mcnt_nxt;
    end
  end
  assign sts.mod_done = (mcnt_r == 6'd0);

  // Stores.
  logic [rwss_pkg::LaW-1:0]  lit_ra;
  logic [rwss_pkg::LitW-1:0] lit_rd;
  logic [rwss_pkg::CiW-1:0]  len_ra, len_wa;
  logic [2:0]                len_rd, len_wd;
  logic                      len_wen;
  logic [rwss_pkg::CiW-1:0]  vl_wa, vl_ra;
  logic [rwss_pkg::CiW-1:0]  vl_rd;
  logic                      vl_we;

  rwss_ram #(.Width(rwss_pkg::LitW), .Depth(rwss_pkg::MaxClauses * rwss_pkg::MaxLits)) u_lit (
    .clk(clk), .we(lit_we), .waddr({ld_ci, ld_slot}), .wdata({ld_neg, ld_var}),
    .raddr(lit_ra), .rdata(lit_rd)
  );

  assign len_wen = len_we | (cmd.clr_pass & ~clr_r[rwss_pkg::CiW]);
  assign len_wa  = cmd.clr_pass ? clr_r[rwss_pkg::CiW-1:0] : ld_ci;
  assign len_wd  = cmd.clr_pass ? 3'd0 : ((ld_len > 3'd4) ? 3'd4 : ld_len);

  rwss_ram #(.Width(3), .Depth(rwss_pkg::MaxClauses)) u_len (
    .clk(clk), .we(len_wen), .waddr(len_wa), .wdata(len_wd),
    .raddr(len_ra), .rdata(len_rd)
  );

  rwss_ram #(.Width(rwss_pkg::CiW), .Depth(rwss_pkg::MaxClauses)) u_viol (
    .clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(sc_r[rwss_pkg::CiW-1:0]),
    .raddr(vl_ra), .rdata(vl_rd)
  );

  assign vl_ra = mrem_r[rwss_pkg::CiW-1:0];
  assign vl_wa = vcnt_r[rwss_pkg::CiW-1:0];

  // Literal truth of the word coming out of the literal store.
  logic [6:0] lv;
  logic       lt;
  assign lv = lit_rd[6:0];
  assign lt = (lv != 7'd0) && (lv <= nv) && (asg_r[lv[5:0] - 6'd1] ^ lit_rd[7]);

  logic [1:0] pick_slot;
  assign pick_slot = mrem_r[1:0];

  always_comb begin
    len_ra = cmd.rd_len ? vl_rd : sc_r[rwss_pkg::CiW-1:0];
    if (cmd.rd_lit) begin
      lit_ra = {pc_r, pick_slot};
    end else begin
      lit_ra = {sc_r[rwss_pkg::CiW-1:0], sj_r[1:0]};
    end
  end

  // Sweep sequencing. Lengths and literals come in the cycle after their address.
  always_comb begin
    sw_nxt    = sw_r;
    sc_nxt    = sc_r;
    sj_nxt    = sj_r;
    slen_nxt  = slen_r;
    shold_nxt = shold_r;
    vcnt_nxt  = vcnt_r;
    sdone_nxt = sdone_r;
    vl_we     = 1'b0;
    if (cmd.scan_start) begin
      sc_nxt    = '0;
      vcnt_nxt  = '0;
      sdone_nxt = (nc == '0);
      sw_nxt    = (nc == '0) ? SW_IDLE : SW_LEN;
      sj_nxt    = '0;
    end else if (cmd.scan_step) begin
      case (sw_r)
        SW_LEN: begin
          // Length address was sc_r; data arrives next cycle.
          sw_nxt = SW_LIT;
          sj_nxt = '0;
          shold_nxt = 1'b0;
        end
        SW_LIT: begin
          slen_nxt = len_rd;
          if (len_rd == 3'd0) begin
            sw_nxt = SW_EVAL;
          end else begin
            sj_nxt = 3'd1;
            sw_nxt = SW_EVAL;
          end
        end
        SW_EVAL: begin
          // lit_rd holds literal sj_r-1 when sj_r > 0.
          if (sj_r != 3'd0 && lt) begin
            shold_nxt = 1'b1;
          end
          if (sj_r < slen_r && !(sj_r != 3'd0 && lt)) begin
            sj_nxt = sj_r + 3'd1;
          end else begin
            if (!(shold_r || (sj_r != 3'd0 && lt))) begin
              vl_we    = 1'b1;
              vcnt_nxt = vcnt_r + 1'b1;
            end
            if (sc_r + 1'b1 >= nc) begin
              sw_nxt    = SW_IDLE;
              sdone_nxt = 1'b1;
            end else begin
              sc_nxt = sc_r + 1'b1;
              sw_nxt = SW_LEN;
            end
          end
        end
        default: sw_nxt = SW_IDLE;
      endcase
    end
  end

  // Literal address in SW_EVAL must be the literal whose result shows next cycle.
  // sj_r counts literals issued; lit_ra uses sj_r[1:0], so the address is the
  // next literal while data is for the previous one.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= SW_IDLE;
      sdone_r <= 1'b0;
      vcnt_r  <= '0;
    end else begin
      sw_r    <= sw_nxt;
      sdone_r <= cmd.scan_start ? sdone_nxt : (sdone_nxt & ~cmd.scan_start);
      vcnt_r  <= vcnt_nxt;
    end
    sc_r    <= sc_nxt;
    sj_r    <= sj_nxt;
    slen_r  <= slen_nxt;
    shold_r <= shold_nxt;
  end
  assign sts.scan_done = sdone_r & (sw_r == SW_IDLE) & ~cmd.scan_start;
  assign sts.viol_zero = (vcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.rd_len) begin
      pc_r <= vl_rd;
    end
    if (cmd.pick_lit) begin
      plen_r <= plen_r;
    end else if (cmd.rd_viol) begin
      plen_r <= len_rd;
    end
    if (cmd.flip) begin
      flip_var_r <= flip_var_r;
    end else begin
      flip_var_r <= lit_rd[6:0];
    end
  end
  assign sts.len_zero = (len_rd == 3'd0);

endmodule

/* hw/rtl/rwss_ctrl.sv */
// Controller state machine of the solver: sequences attempts, steps and picks.
// Depends on rwss_pkg.
module rwss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       max_steps,
  input  logic [7:0]        max_attempts,
  input  rwss_pkg::dp_sts_t sts,
  output rwss_pkg::dp_cmd_t cmd,
  output logic              ready,
  output logic              fin,
  output logic              found,
  output logic [7:0]        attempts
);
  typedef enum logic [13:0] {
    S_CLR    = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_ATT    = 14'b00000000000100,
    S_INIT   = 14'b00000000001000,
    S_SCAN0  = 14'b00000000010000,
    S_SCAN   = 14'b00000000100000,
    S_PICKC  = 14'b00000001000000,
    S_MODC   = 14'b00000010000000,
    S_VRD    = 14'b00000100000000,
    S_LRD    = 14'b00001000000000,
    S_MODL   = 14'b00010000000000,
    S_LITRD  = 14'b00100000000000,
    S_FLIP   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } st_t;

  st_t        st_r, st_nxt;
  logic [15:0] step_r, step_nxt;
  logic [7:0]  att_r, att_nxt;
  logic        fnd_r, fnd_nxt;
  logic        lw_r, lw_nxt;    // wait flag for a store read

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    att_nxt  = att_r;
    fnd_nxt  = fnd_r;
    lw_nxt   = 1'b0;
    cmd      = '0;
    case (st_r)
      S_CLR: begin
        cmd.clr_pass = 1'b1;
        if (sts.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          att_nxt = '0;
          fnd_nxt = 1'b0;
          st_nxt  = S_ATT;
        end
      end
      S_ATT: begin
        if (fnd_r || att_r >= max_attempts) begin
          st_nxt = S_DONE;
        end else begin
          att_nxt = att_r + 8'd1;
          cmd.clr_assign = 1'b1;
          step_nxt = '0;
          st_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (sts.init_done) begin
          st_nxt = S_SCAN0;
        end else begin
          cmd.init_bit = 1'b1;
        end
      end
      S_SCAN0: begin
        if (step_r >= max_steps) begin
          st_nxt = S_ATT;
        end else begin
          cmd.scan_start = 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.viol_zero) begin
            fnd_nxt = 1'b1;
            st_nxt  = S_ATT;
          end else begin
            st_nxt = S_PICKC;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_PICKC: begin
        cmd.pick_clause = 1'b1;
        st_nxt = S_MODC;
      end
      S_MODC: begin
        if (sts.mod_done) begin
          st_nxt = S_VRD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_VRD: begin
        // Violated list data valid next cycle.
        lw_nxt = ~lw_r;
        if (lw_r) begin
          cmd.rd_len = 1'b1;
          st_nxt = S_LRD;
        end
      end
      S_LRD: begin
        // The length of the picked clause is on the store output in this cycle.
        cmd.rd_viol = 1'b1;
        if (sts.len_zero) begin
          step_nxt = step_r + 16'd1;
          st_nxt = S_SCAN0;
        end else begin
          st_nxt = S_MODL;
        end
      end
      S_MODL: begin
        lw_nxt = ~lw_r;
        if (!lw_r) begin
          cmd.pick_lit = 1'b1;
        end else if (sts.mod_done) begin
          st_nxt = S_LITRD;
        end else begin
          cmd.mod_step = 1'b1;
          lw_nxt = 1'b1;
        end
      end
      S_LITRD: begin
        cmd.rd_lit = 1'b1;
        lw_nxt = ~lw_r;
        if (lw_r) st_nxt = S_FLIP;
      end
      S_FLIP: begin
        cmd.flip = 1'b1;
        step_nxt = step_r + 16'd1;
        st_nxt = S_SCAN0;
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      att_r <= '0;
      fnd_r <= 1'b0;
      lw_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      att_r <= att_nxt;
      fnd_r <= fnd_nxt;
      lw_r  <= lw_nxt;
    end
    step_r <= step_nxt;
  end

  assign ready    = (st_r == S_IDLE);
  assign fin      = (st_r == S_DONE);
  assign found    = fnd_r;
  assign attempts = att_r;
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the random-walk satisfiability solver.
// Depends on rwss_pkg and the random_walk_sat_solver RTL; needs nothing else.
// A scoreboard class mirrors the clause store and the search; plain tasks drive the block.

typedef struct packed {
  bit        found;
  bit [63:0] bits;
  bit [7:0]  tries;
} sat_verdict_t;

class sat_scoreboard;
  bit [7:0]  lit_mem [4096];
  bit [2:0]  len_mem [1024];
  bit [63:0] assign_bits;
  bit [31:0] rng;
  bit [6:0]  nvars;
  bit [10:0] nclauses;
  bit [15:0] steps_lim;
  bit [7:0]  tries_lim;
  sat_verdict_t expected_q[$];

  function new();
    foreach (lit_mem[i]) lit_mem[i] = '0;
    foreach (len_mem[i]) len_mem[i] = '0;
    assign_bits = '0;
    rng = 32'd1;
    nvars = 7'd1;
    nclauses = 11'd1;
    steps_lim = 16'd40960;
    tries_lim = 8'd100;
  endfunction

  function void write_reg(rwss_pkg::cfg_idx_t idx, bit [31:0] d);
    case (idx)
      rwss_pkg::CFG_NUM_VARS:     nvars = d[6:0];
      rwss_pkg::CFG_NUM_CLAUSES:  nclauses = d[10:0];
      rwss_pkg::CFG_MAX_STEPS:    steps_lim = d[15:0];
      rwss_pkg::CFG_MAX_ATTEMPTS: tries_lim = d[7:0];
      rwss_pkg::CFG_RNG_SEED:     rng = (d == 0) ? 32'd1 : d;
      default: ;
    endcase
  endfunction

  // Advance the xorshift generator once and return the new state.
  function bit [31:0] next_rand();
    rng = rng ^ (rng << 13);
    rng = rng ^ (rng >> 17);
    rng = rng ^ (rng << 5);
    return rng;
  endfunction

  function bit lit_holds(bit [7:0] l, int nv);
    int v;
    v = l[6:0];
    if (v == 0 || v > nv) return 1'b0;
    return l[7] ? !assign_bits[v-1] : assign_bits[v-1];
  endfunction

  function sat_verdict_t search();
    int nv, nc, c, clen, v;
    int viol[$];
    bit found;
    bit holds;
    bit [7:0] used;
    bit [31:0] r;
    sat_verdict_t res;
    nv = (nvars > 64) ? 64 : nvars;
    nc = (nclauses > 1024) ? 1024 : nclauses;
    found = 1'b0;
    used = '0;
    for (int a = 0; a < tries_lim && !found; a++) begin
      used = a + 1;
      assign_bits = '0;
      for (int i = 0; i < nv; i++) begin
        r = next_rand();
        assign_bits[i] = r[0];
      end
      for (int s = 0; s < steps_lim; s++) begin
        viol.delete();
        for (int k = 0; k < nc; k++) begin
          holds = 1'b0;
          for (int j = 0; j < len_mem[k]; j++)
            if (lit_holds(lit_mem[k*4+j], nv)) holds = 1'b1;
          if (!holds) viol.push_back(k);
        end
        if (viol.size() == 0) begin
          found = 1'b1;
          break;
        end
        r = next_rand();
        c = viol[r % viol.size()];
        clen = len_mem[c];
        if (clen > 0) begin
          r = next_rand();
          v = lit_mem[c*4 + (r % clen)] & 8'h7f;
          if (v >= 1 && v <= nv) assign_bits[v-1] = !assign_bits[v-1];
        end
      end
    end
    res.found = found;
    res.bits = found ? assign_bits : 64'd0;
    res.tries = used;
    return res;
  endfunction

  // Update the mirror with one accepted request; a start queues a verdict.
  function void note_request(rwss_pkg::cmd_t cmd, int ci, int slot, int vr, int neg, int len);
    case (cmd)
      rwss_pkg::CMD_LOAD_LIT: lit_mem[ci*4+slot] = {neg[0], vr[6:0]};
      rwss_pkg::CMD_SET_LEN:  len_mem[ci] = (len > 4) ? 3'd4 : len[2:0];
      rwss_pkg::CMD_START:    expected_q.push_back(search());
      default: ;
    endcase
  endfunction

  function string check_result(sat_verdict_t got);
    sat_verdict_t exp_v;
    string msg;
    if (expected_q.size() == 0) return "result with no start pending";
    exp_v = expected_q.pop_front();
    msg = "";
    if (got.found != exp_v.found)
      msg = {msg, $sformatf(" found %0d/%0d", got.found, exp_v.found)};
    if (got.bits != exp_v.bits)
      msg = {msg, $sformatf(" assignment %h/%h", got.bits, exp_v.bits)};
    if (got.tries != exp_v.tries)
      msg = {msg, $sformatf(" attempts %0d/%0d", got.tries, exp_v.tries)};
    return (msg == "") ? "" : {"result (got/exp):", msg};
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rwss_pkg::*;

  localparam int IdleLimit = 100000;  // cycles with no handshake at all
  localparam int HoldCycles = 3000;   // long receiver hold-off for back-pressure

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [9:0]  in_clause_index;
  logic [1:0]  in_literal_slot;
  logic [6:0]  in_literal_var;
  logic        in_literal_negative;
  logic [2:0]  in_clause_length;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic [63:0] out_assignment;
  logic [7:0]  out_attempts_used;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  sat_scoreboard sb = new();
  int  errors = 0;
  int  idle_count = 0;
  bit  quiet = 1'b0;       // when set, neither side inserts gaps
  bit  hold_req = 1'b0;    // asks the receiver for one long hold-off
  bit [3:0] wr_mask [1024]; // which literal slots of each clause were written

  random_walk_sat_solver i_dut (.*);

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    $display("[%0t] %s", $time, msg);
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until the block takes it. Called right after
  // a rising edge; valid is not dropped between back-to-back requests.
  task automatic send_request(cmd_t cmd, int ci, int slot, int vr, int neg, int len);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cmd              <= cmd;
    in_clause_index     <= ci[9:0];
    in_literal_slot     <= slot[1:0];
    in_literal_var      <= vr[6:0];
    in_literal_negative <= neg[0];
    in_clause_length    <= len[2:0];
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, ci, slot, vr, neg, len);
  endtask

  task automatic load_lit(int ci, int slot, int vr, int neg);
    wr_mask[ci][slot] = 1'b1;
    send_request(CMD_LOAD_LIT, ci, slot, vr, neg, $urandom_range(0, 7));
  endtask

  // Lengths never reach past the written slots, so no unwritten literal is read.
  task automatic set_len(int ci, int len);
    int pre;
    pre = 0;
    while (pre < 4 && wr_mask[ci][pre]) pre++;
    if (((len > 4) ? 4 : len) > pre) len = pre;
    send_request(CMD_SET_LEN, ci, $urandom_range(0, 3), $urandom_range(0, 127),
                 $urandom_range(0, 1), len);
  endtask

  task automatic start_search();
    send_request(CMD_START, $urandom_range(0, 1023), $urandom_range(0, 3),
                 $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 7));
  endtask

  // Wait until every search result is back, then give the block time to settle
  // before the registers change.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_regs(int nv, int nc, int steps, int tries, bit [31:0] seed);
    bit [31:0] vals [5];
    cfg_idx_t idx;
    vals = '{nv, nc, steps, tries, seed};
    for (int i = 0; i < 5; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Literal variables mostly sit in range or one past it, sometimes anywhere in the field.
  function automatic int rand_var(int nv);
    int top;
    top = (nv > 64 ? 64 : nv) + 1;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, top);
    return $urandom_range(0, 127);
  endfunction

  // Receiver: checks each accepted result, then decides out_ready for the next cycle.
  initial begin
    sat_verdict_t got;
    string msg;
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.found = out_found;
        got.bits  = out_assignment;
        got.tries = out_attempts_used;
        msg = sb.check_result(got);
        if (msg != "") report(msg);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int nv, nc, cnt, r, c, k, len;
    foreach (wr_mask[i]) wr_mask[i] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NONE;
    in_clause_index = '0;
    in_literal_slot = '0;
    in_literal_var = '0;
    in_literal_negative = 1'b0;
    in_clause_length = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NUM_VARS;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero seed must load as one.
    write_regs(3, 3, 20, 3, 0);
    load_lit(0, 0, 1, 0);
    load_lit(0, 1, 2, 1);
    set_len(0, 2);
    // Clause 1 mixes variable zero and variables beyond num_vars with one real
    // literal, and its oversized length is stored as four.
    load_lit(1, 0, 0, 0);
    load_lit(1, 1, 127, 1);
    load_lit(1, 2, 3, 0);
    load_lit(1, 3, 64, 0);
    set_len(1, 5);
    load_lit(2, 0, 3, 1);
    set_len(2, 1);
    load_lit(1023, 3, 127, 1);
    set_len(1023, 0);
    send_request(CMD_NONE, 1023, 3, 127, 1, 7);
    // Two starts in a row: the generator carries over between them.
    start_search();
    start_search();
    // No attempts at all and no variables.
    drain();
    write_regs(0, 3, 20, 0, 5);
    start_search();
    // Zero steps, most attempts, num_vars saturating, all-ones seed.
    drain();
    write_regs(127, 3, 0, 255, 32'hffff_ffff);
    start_search();
    // No clauses in use: holds at the first check, even with the step maximum.
    drain();
    write_regs(64, 0, 65535, 1, 7);
    start_search();
    // Clause count saturating at the store size; most clauses are empty.
    drain();
    write_regs(64, 2047, 2, 1, 9);
    start_search();

    // Random phases: mostly well-formed clause definitions followed by starts,
    // mixed with stray loads, length writes and unknown commands.
    for (int ph = 0; ph < 20; ph++) begin
      drain();
      quiet = (ph % 4 == 1);
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 127) : $urandom_range(1, 8);
      nc = $urandom_range(1, 6);
      write_regs(nv, nc, $urandom_range(1, 16), $urandom_range(1, 3), $urandom);
      if (ph == 5) begin
        // Back-pressure: the receiver holds off while starts keep coming.
        hold_req = 1'b1;
        repeat (5) start_search();
      end
      cnt = 0;
      while (cnt < 55) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          c = $urandom_range(0, nc - 1);
          k = $urandom_range(1, 4);
          for (int j = 0; j < k; j++) load_lit(c, j, rand_var(nv), $urandom_range(0, 1));
          len = (k == 4) ? $urandom_range(0, 7) : $urandom_range(0, k);
          if ($urandom_range(0, 3) != 0 && k < 4) len = k;
          set_len(c, len);
          cnt += k + 1;
        end else if (r < 60) begin
          start_search();
          cnt++;
        end else if (r < 75) begin
          load_lit($urandom_range(0, 1023), $urandom_range(0, 3), $urandom_range(0, 127),
                   $urandom_range(0, 1));
          cnt++;
        end else if (r < 85) begin
          c = ($urandom_range(0, 1) == 0) ? $urandom_range(0, nc - 1) : $urandom_range(0, 1023);
          set_len(c, $urandom_range(0, 7));
          cnt++;
        end else begin
          send_request(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 3),
                       $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 7));
          cnt++;
        end
      end
    end

    quiet = 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rwss_pkg.sv
hw/rtl/rwss_ram.sv
hw/rtl/rwss_dp.sv
hw/rtl/rwss_ctrl.sv
hw/rtl/random_walk_sat_solver.sv
tb/tb_top.sv
